### rtl/loonn_pkg.sv
package loonn_pkg;

  localparam int unsigned MAX_ROWS_DEF    = 1024;
  localparam int unsigned MAX_COLUMNS_DEF = 64;
  localparam int unsigned VALUE_WIDTH_DEF = 16;

  localparam int unsigned PERCENT_Q8 = 25600;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned ACC_W      = 15;
  localparam int unsigned ROW_IDX_W  = 10;
  localparam int unsigned COL_IDX_W  = 6;
  localparam int unsigned ELEM_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_FEATURE_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic load;        // write one element from the request
    logic start;       // clear the run counters
    logic row_begin;   // start a new query row i
    logic pair_begin;  // start a new candidate row k
    logic rd_a;        // read element (i,f)
    logic rd_b;        // read element (k,f)
    logic accum;       // add squared difference of the last pair
    logic compare;     // finish candidate: compare with best
    logic label_a;     // read label of row i
    logic label_b;     // read label of best row
    logic score;       // compare labels, count
    logic div_start;   // start the accuracy division
  } loonn_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic last_col;    // feature column is the last one
    logic skip_pair;   // k equals i
    logic last_k;      // candidate is the last row
    logic last_i;      // query is the last row
    logic div_done;
  } loonn_sts_t;

endpackage

### rtl/loonn_ctrl.sv
module loonn_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_op,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  loonn_pkg::loonn_sts_t sts,
  output loonn_pkg::loonn_cmd_t cmd
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_ROW   = 13'b0000000000010,
    S_PAIR  = 13'b0000000000100,
    S_RDA   = 13'b0000000001000,
    S_RDB   = 13'b0000000010000,
    S_ACC   = 13'b0000000100000,
    S_SQ    = 13'b0000001000000,
    S_SUM   = 13'b0000010000000,
    S_CMP   = 13'b0000100000000,
    S_LBLA  = 13'b0001000000000,
    S_LBLB  = 13'b0010000000000,
    S_DIV   = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_t;

  state_t state, state_next;
  logic   accum_pend, accum_pend_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      accum_pend <= 1'b0;
    end else begin
      state      <= state_next;
      accum_pend <= accum_pend_next;
    end
  end

  always_comb begin
    state_next      = state;
    accum_pend_next = 1'b0;
    cmd             = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == loonn_pkg::OP_EVAL) begin
            cmd.start  = 1'b1;
            state_next = S_ROW;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_ROW: begin
        cmd.row_begin = 1'b1;
        state_next    = S_PAIR;
      end
      S_PAIR: begin
        if (sts.skip_pair) begin
          cmd.compare = 1'b0;
          // advance k without a distance when k == i
          cmd.pair_begin = 1'b1;
          if (sts.last_k) state_next = S_LBLA;
        end else begin
          state_next = S_RDA;
        end
      end
      S_RDA: begin
        cmd.rd_a = 1'b1;
        state_next = S_RDB;
      end
      S_RDB: begin
        cmd.rd_b = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.accum = 1'b1;
        if (sts.last_col) state_next = S_SQ;
        else state_next = S_RDA;
      end
      // hold until the last square has reached the running sum
      S_SQ: begin
        state_next = S_SUM;
      end
      S_SUM: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.compare    = 1'b1;
        cmd.pair_begin = 1'b1;
        if (sts.last_k) state_next = S_LBLA;
        else state_next = S_PAIR;
      end
      S_LBLA: begin
        cmd.label_a = 1'b1;
        state_next  = S_LBLB;
      end
      S_LBLB: begin
        if (!accum_pend) begin
          cmd.label_b     = 1'b1;
          accum_pend_next = 1'b1;
        end else begin
          cmd.score = 1'b1;
          if (sts.last_i) begin
            // start the division once the last count has landed
            accum_pend_next = 1'b1;
            state_next      = S_DIV;
          end else begin
            state_next = S_ROW;
          end
        end
      end
      S_DIV: begin
        if (accum_pend) cmd.div_start = 1'b1;
        else if (sts.div_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == S_IDLE) else $error("load outside idle");
  a_out_after_div: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DIV) else $error("result without division");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ready) else $error("ready while busy");

endmodule

### rtl/loonn_datapath.sv
module loonn_datapath #(
  parameter int unsigned MAX_ROWS    = loonn_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLUMNS = loonn_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned VALUE_WIDTH = loonn_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [loonn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [loonn_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [loonn_pkg::ROW_IDX_W-1:0]      row_index,
  input  logic [loonn_pkg::COL_IDX_W-1:0]      column_index,
  input  logic signed [loonn_pkg::ELEM_W-1:0]  element_value,
  input  loonn_pkg::loonn_cmd_t                cmd,
  output loonn_pkg::loonn_sts_t                sts,
  output logic [loonn_pkg::COUNT_W-1:0]        correct_count,
  output logic [loonn_pkg::ACC_W-1:0]          accuracy_q8
);

  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned RCW   = $clog2(MAX_ROWS + 1);
  localparam int unsigned CCW   = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int unsigned AW    = RW + CW;
  localparam int unsigned DW    = VALUE_WIDTH + 1;
  localparam int unsigned SQW   = 2 * DW;
  localparam int unsigned SUMW  = SQW + CW;
  localparam int unsigned NUMW  = loonn_pkg::COUNT_W + 15;

  logic signed [VALUE_WIDTH-1:0] mem [DEPTH];
  logic signed [VALUE_WIDTH-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;

  logic [63:0]          feature_mask;
  logic [10:0]          row_count;
  logic [6:0]           column_count;
  logic [RCW-1:0]       rows;
  logic [CCW-1:0]       cols;

  logic [RW-1:0]        qi, kk, best_row;
  logic [CW-1:0]        fc;
  logic                 found;
  logic [SUMW-1:0]      sum, best;
  logic signed [VALUE_WIDTH-1:0] va, lbl_a;
  logic signed [DW-1:0] diff;
  logic                 diff_en;
  logic [SQW-1:0]       sq;
  logic                 sq_en;
  logic [loonn_pkg::COUNT_W-1:0] correct;

  logic [NUMW-1:0]      rem;
  logic [NUMW-1:0]      quo;
  logic [4:0]           div_cnt;
  logic                 div_busy;
  logic [NUMW:0]        rem_sh;

  // register writes and saturation
  always_ff @(posedge clk) begin
    if (rst) begin
      feature_mask <= '0;
      row_count    <= 11'd2;
      column_count <= 7'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        loonn_pkg::REG_FEATURE_MASK: feature_mask <= cfg_data;
        loonn_pkg::REG_ROW_COUNT:    row_count    <= cfg_data[10:0];
        loonn_pkg::REG_COLUMN_COUNT: column_count <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if ({21'd0, row_count} < 32'd2) rows = RCW'(2);
    else if ({21'd0, row_count} > MAX_ROWS) rows = RCW'(MAX_ROWS);
    else rows = RCW'(row_count);
    if ({25'd0, column_count} > MAX_COLUMNS) cols = CCW'(MAX_COLUMNS);
    else cols = CCW'(column_count);
  end

  // sample store
  assign wr_en   = cmd.load && ({22'd0, row_index} < MAX_ROWS)
                   && ({26'd0, column_index} < MAX_COLUMNS);
  assign wr_addr = {RW'(row_index), CW'(column_index)};

  always_comb begin
    rd_addr = {qi, fc};
    if (cmd.rd_b) rd_addr = {kk, fc};
    else if (cmd.label_a) rd_addr = {qi, CW'(0)};
    else if (cmd.label_b) rd_addr = {best_row, CW'(0)};
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= VALUE_WIDTH'(element_value);
    rd_data <= mem[rd_addr];
  end

  // feature column walk: fc steps 1..cols-1, masked columns add zero
  logic fc_on;
  assign fc_on = (fc != '0) && ({1'b0, fc} < cols) && feature_mask[fc];
  assign sts.last_col  = ({1'b0, fc} + 1'b1 >= cols) || (fc == CW'(MAX_COLUMNS - 1));
  assign sts.skip_pair = (kk == qi);
  assign sts.last_k    = ({1'b0, kk} + 1'b1 >= rows) || (kk == RW'(MAX_ROWS - 1));
  assign sts.last_i    = ({1'b0, qi} + 1'b1 >= rows) || (qi == RW'(MAX_ROWS - 1));
  assign sts.div_done  = div_busy && (div_cnt == 5'd0);

  logic cur_on;
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qi      <= '0;
      correct <= '0;
    end
    if (cmd.row_begin) begin
      kk    <= '0;
      found <= 1'b0;
      fc    <= CW'(1);
      sum   <= '0;
    end
    if (cmd.rd_a) begin
      cur_on <= fc_on;
    end
    if (cmd.rd_b) va <= rd_data;
    // rd_b cycle registers element a; accum cycle has element b
    diff_en <= 1'b0;
    sq_en   <= 1'b0;
    if (cmd.accum) begin
      diff    <= DW'(va) - DW'(rd_data);
      diff_en <= cur_on;
      fc      <= fc + 1'b1;
    end
    if (diff_en) begin
      sq    <= SQW'(diff * diff);
      sq_en <= 1'b1;
    end
    if (sq_en) sum <= sum + SUMW'(sq);
    if (cmd.compare) begin
      if (!found || sum < best) begin
        best     <= sum;
        best_row <= kk;
      end
      found <= 1'b1;
    end
    if (cmd.pair_begin) begin
      kk  <= kk + 1'b1;
      fc  <= CW'(1);
      sum <= '0;
    end
    // label of row i arrives in the cycle that issues the best-row read
    if (cmd.label_b) lbl_a <= rd_data;
    if (cmd.score) begin
      if (lbl_a == rd_data) correct <= correct + 1'b1;
      qi <= qi + 1'b1;
    end
  end

  // restoring division: correct*25600 / rows, one quotient bit a cycle
  assign rem_sh = {rem, quo[NUMW-1]};
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
      div_cnt  <= 5'(NUMW);
      rem      <= '0;
      quo      <= NUMW'(correct * 15'(loonn_pkg::PERCENT_Q8));
    end else if (div_busy && div_cnt != 5'd0) begin
      div_cnt <= div_cnt - 1'b1;
      if (rem_sh[NUMW-1:0] >= NUMW'(rows)) begin
        rem <= rem_sh[NUMW-1:0] - NUMW'(rows);
        quo <= {quo[NUMW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[NUMW-1:0];
        quo <= {quo[NUMW-2:0], 1'b0};
      end
    end else if (div_busy) begin
      div_busy <= 1'b0;
    end
  end

  assign correct_count = correct;
  assign accuracy_q8   = quo[loonn_pkg::ACC_W-1:0];

endmodule

### rtl/loo_nearest_neighbor_accuracy_core.sv
// Leave-one-out 1-NN accuracy. Loads (op 0) write one store element each and leave
// the core idle, so the next request may follow. An evaluation (op 1) walks every
// ordered pair of distinct active rows, two store reads per feature column through
// the single read port of the sample memory, then waits in S_SQ and S_SUM for the
// square and sum pipeline before the compare; the result holds on the output until
// taken, and the next request is accepted after that.
module loo_nearest_neighbor_accuracy_core #(
  parameter int unsigned MAX_ROWS    = loonn_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLUMNS = loonn_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned VALUE_WIDTH = loonn_pkg::VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // row_index[9:0], column_index[15:10], element_value[31:16]
  input  logic        s_tuser,  // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // correct_count[10:0], accuracy_q8[25:11]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  loonn_pkg::loonn_cmd_t cmd;
  loonn_pkg::loonn_sts_t sts;
  logic [10:0] correct_count;
  logic [14:0] accuracy_q8;

  loonn_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_op(s_tuser), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .sts(sts), .cmd(cmd)
  );

  loonn_datapath #(
    .MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS), .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .row_index(s_tdata[9:0]), .column_index(s_tdata[15:10]),
    .element_value(s_tdata[31:16]),
    .cmd(cmd), .sts(sts),
    .correct_count(correct_count), .accuracy_q8(accuracy_q8)
  );

  assign m_tdata = {6'd0, accuracy_q8, correct_count};

endmodule
